/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  `ASSERT_PROP(lbl, clk, rst_n, (pre) |=> (post))

`endif

/* rtl/rna_pkg.sv */
// Shared types and constants of the rational number ALU.
// No dependencies; used by rna_ctrl, rna_dpath and rational_number_alu.
package rna_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_UNS  = 2'd3;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_GCD_DEN,
    CMD_GCD_RED,
    CMD_GCD_STEP,
    CMD_DIV_X,
    CMD_DIV_Y,
    CMD_DIV_N,
    CMD_DIV_D,
    CMD_DIV_STEP,
    CMD_SAVE_D,
    CMD_MUL_T1,
    CMD_MUL_T2,
    CMD_MUL_DX,
    CMD_MUL_NN,
    CMD_MUL_DD,
    CMD_MUL_NDIV,
    CMD_MUL_DDIV,
    CMD_POW_N,
    CMD_POW_D,
    CMD_POW_MUL,
    CMD_POW_CHK,
    CMD_POW_SAVE,
    CMD_ONE,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] err;
    logic       sel;   // power save target: 0 numerator, 1 denominator
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       zden;
    logic       an_zero;
    logic       bn_zero;
    logic       b_neg;
    logic       b_frac;
    logic       gcd_done;
    logic       div_done;
    logic       pow_trivial;
    logic       pow_stop;
  } stat_t;

endpackage

/* rtl/rna_ctrl.sv */
// Sequencer of the rational number ALU: handshakes and datapath commands.
// Depends on rna_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rna_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  rna_pkg::stat_t stat_i,
  output rna_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_G1, S_DX, S_DY, S_T2, S_T3, S_MD, S_DD, S_RED,
    S_G2, S_DN, S_DDN, S_PTST, S_PMUL, S_PCHK, S_PSAVE, S_PDINIT, S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] err_q, err_d;
  logic       pd_q, pd_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    pd_d        = pd_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = rna_pkg::CMD_NOP;
    cmd_o.err   = err_q;
    cmd_o.sel   = pd_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rna_pkg::CMD_LOAD;
          err_d    = rna_pkg::ST_OK;
          pd_d     = 1'b0;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.opcode > rna_pkg::OP_POW) begin
          err_d   = rna_pkg::ST_UNS;
          state_d = S_OUT;
        end else if (stat_i.zden) begin
          err_d   = rna_pkg::ST_DIVZ;
          state_d = S_OUT;
        end else begin
          case (stat_i.opcode)
            rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin
              cmd_o.op = rna_pkg::CMD_GCD_DEN;
              state_d  = S_G1;
            end
            rna_pkg::OP_MUL: begin
              cmd_o.op = rna_pkg::CMD_MUL_NN;
              state_d  = S_MD;
            end
            rna_pkg::OP_DIV: begin
              if (stat_i.bn_zero) begin
                err_d   = rna_pkg::ST_DIVZ;
                state_d = S_OUT;
              end else begin
                cmd_o.op = rna_pkg::CMD_MUL_NDIV;
                state_d  = S_DD;
              end
            end
            default: begin
              if (stat_i.b_frac) begin
                err_d   = rna_pkg::ST_UNS;
                state_d = S_OUT;
              end else if (stat_i.bn_zero) begin
                cmd_o.op = rna_pkg::CMD_ONE;
                state_d  = S_OUT;
              end else if (stat_i.b_neg && stat_i.an_zero) begin
                err_d   = rna_pkg::ST_DIVZ;
                state_d = S_OUT;
              end else begin
                cmd_o.op = rna_pkg::CMD_POW_N;
                state_d  = S_PTST;
              end
            end
          endcase
        end
      end
      S_G1: begin
        if (stat_i.gcd_done) begin
          cmd_o.op = rna_pkg::CMD_DIV_X;
          state_d  = S_DX;
        end else begin
          cmd_o.op = rna_pkg::CMD_GCD_STEP;
        end
      end
      S_DX: begin
        if (stat_i.div_done) begin
          cmd_o.op = rna_pkg::CMD_DIV_Y;
          state_d  = S_DY;
        end else begin
          cmd_o.op = rna_pkg::CMD_DIV_STEP;
        end
      end
      S_DY: begin
        if (stat_i.div_done) begin
          cmd_o.op = rna_pkg::CMD_MUL_T1;
          state_d  = S_T2;
        end else begin
          cmd_o.op = rna_pkg::CMD_DIV_STEP;
        end
      end
      S_T2: begin
        cmd_o.op = rna_pkg::CMD_MUL_T2;
        state_d  = S_T3;
      end
      S_T3: begin
        cmd_o.op = rna_pkg::CMD_MUL_DX;
        state_d  = S_RED;
      end
      S_MD: begin
        cmd_o.op = rna_pkg::CMD_MUL_DD;
        state_d  = S_RED;
      end
      S_DD: begin
        cmd_o.op = rna_pkg::CMD_MUL_DDIV;
        state_d  = S_RED;
      end
      S_RED: begin
        cmd_o.op = rna_pkg::CMD_GCD_RED;
        state_d  = S_G2;
      end
      S_G2: begin
        if (stat_i.gcd_done) begin
          cmd_o.op = rna_pkg::CMD_DIV_N;
          state_d  = S_DN;
        end else begin
          cmd_o.op = rna_pkg::CMD_GCD_STEP;
        end
      end
      S_DN: begin
        if (stat_i.div_done) begin
          cmd_o.op = rna_pkg::CMD_DIV_D;
          state_d  = S_DDN;
        end else begin
          cmd_o.op = rna_pkg::CMD_DIV_STEP;
        end
      end
      S_DDN: begin
        if (stat_i.div_done) begin
          cmd_o.op = rna_pkg::CMD_SAVE_D;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = rna_pkg::CMD_DIV_STEP;
        end
      end
      S_PTST: begin
        if (stat_i.pow_trivial) begin
          state_d = S_PSAVE;
        end else begin
          cmd_o.op = rna_pkg::CMD_POW_MUL;
          state_d  = S_PCHK;
        end
      end
      S_PMUL: begin
        cmd_o.op = rna_pkg::CMD_POW_MUL;
        state_d  = S_PCHK;
      end
      S_PCHK: begin
        cmd_o.op = rna_pkg::CMD_POW_CHK;
        state_d  = stat_i.pow_stop ? S_PSAVE : S_PMUL;
      end
      S_PSAVE: begin
        cmd_o.op = rna_pkg::CMD_POW_SAVE;
        state_d  = pd_q ? S_OUT : S_PDINIT;
      end
      S_PDINIT: begin
        cmd_o.op = rna_pkg::CMD_POW_D;
        pd_d     = 1'b1;
        state_d  = S_PTST;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = rna_pkg::CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= rna_pkg::ST_OK;
      pd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      pd_q        <= pd_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_NEXT(a_accept_check, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_CHECK)
  `ASSERT_PROP(a_out_free, clk_i, rst_ni, (cmd_o.op == rna_pkg::CMD_OUT) |-> (!out_valid_q || !out_stall_i))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q)

endmodule

/* rtl/rna_dpath.sv */
// Datapath of the rational number ALU: operand registers, binary gcd,
// restoring divider, shared 32x32 multiplier and result register.
// Depends on rna_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rna_dpath #(
  parameter int unsigned WORD_BITS = rna_pkg::WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rna_pkg::cmd_t      cmd_i,
  output rna_pkg::stat_t     stat_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic               a_is_frac_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  input  logic               b_is_frac_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic               res_is_frac_o,
  output logic [1:0]         status_o
);

  localparam int unsigned EffBits = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
  localparam logic [63:0] Half    = 64'd1 << (EffBits - 1);
  localparam logic [31:0] CapP1   = 32'(Half + 64'd1);

  localparam logic [1:0] FM_INT  = 2'd0;
  localparam logic [1:0] FM_FRAC = 2'd1;
  localparam logic [1:0] FM_AUTO = 2'd2;

  logic [2:0]  op_q;
  logic        bf_q, zden_q, a_neg_q, b_neg_q, neg_q;
  logic [1:0]  fmode_q;
  logic [31:0] an_q, ad_q, bn_q, bd_q, x_q, y_q;
  logic [63:0] t1_q, t2_q, n_q, d_q;
  logic [63:0] ga_q, gb_q;
  logic [6:0]  gk_q;
  logic [63:0] dv_rem_q, dv_sh_q, dv_den_q;
  logic [6:0]  dv_cnt_q;
  logic [31:0] base_q, r_q, e_q;
  logic [63:0] p_q;
  logic [31:0] res_num_q;
  logic [30:0] res_den_q;
  logic        res_frac_q;
  logic [1:0]  status_q;

  // operand load
  logic [31:0] ua_num, ua_den, ub_num, ub_den;
  logic [31:0] an_m, ad_m, bn_m, bd_m;
  logic        a_neg_c, b_neg_c, zden_c;
  logic [1:0]  fm_c;

  assign ua_num = a_num_i;
  assign ua_den = a_den_i;
  assign ub_num = b_num_i;
  assign ub_den = b_den_i;
  assign an_m   = ua_num[31] ? (~ua_num + 32'd1) : ua_num;
  assign bn_m   = ub_num[31] ? (~ub_num + 32'd1) : ub_num;
  assign ad_m   = a_is_frac_i ? (ua_den[31] ? (~ua_den + 32'd1) : ua_den) : 32'd1;
  assign bd_m   = b_is_frac_i ? (ub_den[31] ? (~ub_den + 32'd1) : ub_den) : 32'd1;
  assign a_neg_c = (ua_num[31] ^ (a_is_frac_i & ua_den[31])) && (an_m != 32'd0);
  assign b_neg_c = (ub_num[31] ^ (b_is_frac_i & ub_den[31])) && (bn_m != 32'd0);
  assign zden_c  = (a_is_frac_i && (ua_den == 32'd0)) || (b_is_frac_i && (ub_den == 32'd0));

  always_comb begin
    case (opcode_i)
      rna_pkg::OP_DIV: fm_c = FM_AUTO;
      rna_pkg::OP_POW: fm_c = (b_neg_c || a_is_frac_i) ? FM_FRAC : FM_INT;
      default:         fm_c = (a_is_frac_i || b_is_frac_i) ? FM_FRAC : FM_INT;
    endcase
  end

  // binary gcd
  logic        gcd_done;
  logic [63:0] gcd_val;
  assign gcd_done = (ga_q == 64'd0) || (gb_q == 64'd0);
  assign gcd_val  = (ga_q | gb_q) << gk_q;

  // restoring divider, one quotient bit per cycle
  logic [64:0] dv_try;
  logic        dv_ge;
  assign dv_try = {dv_rem_q, dv_sh_q[63]};
  assign dv_ge  = (dv_try >= {1'b0, dv_den_q});

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    case (cmd_i.op)
      rna_pkg::CMD_MUL_T1:   begin mul_a = an_q;   mul_b = x_q;    end
      rna_pkg::CMD_MUL_T2:   begin mul_a = bn_q;   mul_b = y_q;    end
      rna_pkg::CMD_MUL_DX:   begin mul_a = ad_q;   mul_b = x_q;    end
      rna_pkg::CMD_MUL_NN:   begin mul_a = an_q;   mul_b = bn_q;   end
      rna_pkg::CMD_MUL_DD:   begin mul_a = ad_q;   mul_b = bd_q;   end
      rna_pkg::CMD_MUL_NDIV: begin mul_a = an_q;   mul_b = bd_q;   end
      rna_pkg::CMD_MUL_DDIV: begin mul_a = ad_q;   mul_b = bn_q;   end
      rna_pkg::CMD_POW_MUL:  begin mul_a = r_q;    mul_b = base_q; end
      default:               begin mul_a = 32'd0;  mul_b = 32'd0;  end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // signed-magnitude sum of the scaled numerators
  logic        bneg_eff, s_neg;
  logic [63:0] s_mag;
  always_comb begin
    bneg_eff = (op_q == rna_pkg::OP_SUB) ? ((bn_q != 32'd0) && !b_neg_q) : b_neg_q;
    if (a_neg_q == bneg_eff) begin
      s_mag = t1_q + t2_q;
      s_neg = a_neg_q;
    end else if (t1_q >= t2_q) begin
      s_mag = t1_q - t2_q;
      s_neg = a_neg_q;
    end else begin
      s_mag = t2_q - t1_q;
      s_neg = bneg_eff;
    end
    if (s_mag == 64'd0) begin
      s_neg = 1'b0;
    end
  end

  // power loop
  logic        pow_trivial, pow_stop;
  logic [31:0] pow_val;
  assign pow_trivial = (base_q <= 32'd1);
  assign pow_stop    = (p_q > Half) || (e_q == 32'd0);
  assign pow_val     = pow_trivial ? base_q : r_q;

  // final range check and sign
  logic        neg_f, ovf_f, frac_f;
  logic [31:0] num_f;
  assign neg_f  = neg_q && (n_q != 64'd0);
  assign ovf_f  = (neg_f ? (n_q > Half) : (n_q > (Half - 64'd1))) || (d_q > (Half - 64'd1));
  assign frac_f = (fmode_q == FM_FRAC) || ((fmode_q == FM_AUTO) && (d_q != 64'd1));
  assign num_f  = neg_f ? (~n_q[31:0] + 32'd1) : n_q[31:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rna_pkg::CMD_LOAD: begin
        op_q    <= opcode_i;
        bf_q    <= b_is_frac_i;
        an_q    <= an_m;
        ad_q    <= ad_m;
        bn_q    <= bn_m;
        bd_q    <= bd_m;
        a_neg_q <= a_neg_c;
        b_neg_q <= b_neg_c;
        zden_q  <= zden_c;
        fmode_q <= fm_c;
      end
      rna_pkg::CMD_GCD_DEN: begin
        ga_q <= 64'(ad_q);
        gb_q <= 64'(bd_q);
        gk_q <= 7'd0;
      end
      rna_pkg::CMD_GCD_RED: begin
        ga_q <= n_q;
        gb_q <= d_q;
        gk_q <= 7'd0;
      end
      rna_pkg::CMD_GCD_STEP: begin
        if (!ga_q[0] && !gb_q[0]) begin
          ga_q <= ga_q >> 1;
          gb_q <= gb_q >> 1;
          gk_q <= gk_q + 7'd1;
        end else if (!ga_q[0]) begin
          ga_q <= ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_q <= gb_q >> 1;
        end else if (ga_q >= gb_q) begin
          ga_q <= ga_q - gb_q;
        end else begin
          gb_q <= gb_q - ga_q;
        end
      end
      rna_pkg::CMD_DIV_X: begin
        dv_rem_q <= 64'd0;
        dv_sh_q  <= {bd_q, 32'd0};
        dv_den_q <= gcd_val;
        dv_cnt_q <= 7'd32;
      end
      rna_pkg::CMD_DIV_Y: begin
        x_q      <= dv_sh_q[31:0];
        dv_rem_q <= 64'd0;
        dv_sh_q  <= {ad_q, 32'd0};
        dv_den_q <= gcd_val;
        dv_cnt_q <= 7'd32;
      end
      rna_pkg::CMD_DIV_N: begin
        dv_rem_q <= 64'd0;
        dv_sh_q  <= n_q;
        dv_den_q <= gcd_val;
        dv_cnt_q <= 7'd64;
      end
      rna_pkg::CMD_DIV_D: begin
        n_q      <= dv_sh_q;
        dv_rem_q <= 64'd0;
        dv_sh_q  <= d_q;
        dv_den_q <= gcd_val;
        dv_cnt_q <= 7'd64;
      end
      rna_pkg::CMD_DIV_STEP: begin
        dv_rem_q <= dv_ge ? 64'(dv_try - {1'b0, dv_den_q}) : dv_try[63:0];
        dv_sh_q  <= {dv_sh_q[62:0], dv_ge};
        dv_cnt_q <= dv_cnt_q - 7'd1;
      end
      rna_pkg::CMD_SAVE_D: begin
        d_q <= dv_sh_q;
      end
      rna_pkg::CMD_MUL_T1: begin
        y_q  <= dv_sh_q[31:0];
        t1_q <= prod;
      end
      rna_pkg::CMD_MUL_T2: begin
        t2_q <= prod;
      end
      rna_pkg::CMD_MUL_DX: begin
        d_q   <= prod;
        n_q   <= s_mag;
        neg_q <= s_neg;
      end
      rna_pkg::CMD_MUL_NN, rna_pkg::CMD_MUL_NDIV: begin
        n_q   <= prod;
        neg_q <= a_neg_q ^ b_neg_q;
      end
      rna_pkg::CMD_MUL_DD, rna_pkg::CMD_MUL_DDIV: begin
        d_q <= prod;
      end
      rna_pkg::CMD_POW_N: begin
        base_q <= b_neg_q ? ad_q : an_q;
        r_q    <= 32'd1;
        e_q    <= bn_q;
        neg_q  <= a_neg_q & bn_q[0];
      end
      rna_pkg::CMD_POW_D: begin
        base_q <= b_neg_q ? an_q : ad_q;
        r_q    <= 32'd1;
        e_q    <= bn_q;
      end
      rna_pkg::CMD_POW_MUL: begin
        p_q <= prod;
        e_q <= e_q - 32'd1;
      end
      rna_pkg::CMD_POW_CHK: begin
        r_q <= (p_q > Half) ? CapP1 : p_q[31:0];
      end
      rna_pkg::CMD_POW_SAVE: begin
        if (cmd_i.sel) begin
          d_q <= 64'(pow_val);
        end else begin
          n_q <= 64'(pow_val);
        end
      end
      rna_pkg::CMD_ONE: begin
        n_q     <= 64'd1;
        d_q     <= 64'd1;
        neg_q   <= 1'b0;
        fmode_q <= FM_INT;
      end
      rna_pkg::CMD_OUT: begin
        if (cmd_i.err != rna_pkg::ST_OK) begin
          res_num_q  <= 32'd0;
          res_den_q  <= 31'd1;
          res_frac_q <= 1'b0;
          status_q   <= cmd_i.err;
        end else if (ovf_f) begin
          res_num_q  <= 32'd0;
          res_den_q  <= 31'd1;
          res_frac_q <= 1'b0;
          status_q   <= rna_pkg::ST_OVF;
        end else begin
          res_num_q  <= num_f;
          res_den_q  <= d_q[30:0];
          res_frac_q <= frac_f;
          status_q   <= rna_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.opcode      = op_q;
  assign stat_o.zden        = zden_q;
  assign stat_o.an_zero     = (an_q == 32'd0);
  assign stat_o.bn_zero     = (bn_q == 32'd0);
  assign stat_o.b_neg       = b_neg_q;
  assign stat_o.b_frac      = bf_q;
  assign stat_o.gcd_done    = gcd_done;
  assign stat_o.div_done    = (dv_cnt_q == 7'd0);
  assign stat_o.pow_trivial = pow_trivial;
  assign stat_o.pow_stop    = pow_stop;

  assign res_num_o     = res_num_q;
  assign res_den_o     = res_den_q;
  assign res_is_frac_o = res_frac_q;
  assign status_o      = status_q;

  `ASSERT_PROP(a_div_cnt, clk_i, rst_ni, (cmd_i.op == rna_pkg::CMD_DIV_STEP) |-> (dv_cnt_q != 7'd0))
  `ASSERT_PROP(a_gcd_live, clk_i, rst_ni, (cmd_i.op == rna_pkg::CMD_GCD_STEP) |-> !gcd_done)

endmodule

/* rtl/rational_number_alu.sv */
// Rational number ALU top level: exact add, subtract, multiply, divide and
// integer power on integer or fraction operands.
// Depends on rna_pkg, rna_ctrl and rna_dpath.
//
// Usage: an item (opcode and two operands) enters on in_valid_i when
// in_stall_o is low. One result item (res_num_o, res_den_o, res_is_frac_o,
// status_o) leaves on out_valid_o; the receiver holds it with out_stall_i.
// One item is worked on at a time. An add or subtract runs two binary gcd
// passes (one step per cycle, first on the denominators, then on the
// reduced pair), four restoring divisions (one quotient bit per cycle) and
// the shared 32x32 multiplier. Power multiplies and then checks each
// product, at most 32 multiplications per part.
// The result sits in an output register, so a new item is accepted while
// the previous result still waits; a stalled receiver holds the result and,
// once the next one is done, the block waits with in_stall_o high.
// Reset (rst_ni low, asynchronous) empties the block: no result pending.
module rational_number_alu #(
  parameter int unsigned WORD_BITS = rna_pkg::WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic               a_is_frac_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  input  logic               b_is_frac_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic               res_is_frac_o,
  output logic [1:0]         status_o
);

  rna_pkg::cmd_t  cmd;
  rna_pkg::stat_t stat;

  rna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rna_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .a_num_i       (a_num_i),
    .a_den_i       (a_den_i),
    .a_is_frac_i   (a_is_frac_i),
    .b_num_i       (b_num_i),
    .b_den_i       (b_den_i),
    .b_is_frac_i   (b_is_frac_i),
    .res_num_o     (res_num_o),
    .res_den_o     (res_den_o),
    .res_is_frac_o (res_is_frac_o),
    .status_o      (status_o)
  );

endmodule
